// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by sha_ctrl, sha_datapath and sha256_stream_hasher; depends on nothing.
package sha_pkg;

    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int WORDS       = 8;
    localparam int WORD_W      = $clog2(WORDS);
    localparam int SCHED_DEPTH = 16;
    localparam int FILL_W      = 6;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
    localparam logic [WORD_W-1:0]  WORD_LAST  = WORD_W'(WORDS - 1);
    localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
    localparam logic [FILL_W-1:0]  FILL_LEN   = 6'd56;
    localparam logic [7:0]         PAD_MARK   = 8'h80;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_ROUND,
        ST_CHAIN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic                push;
        byte_sel_t           byte_sel;
        logic                count_add;
        logic                total_clear;
        logic                load_work;
        logic                round_en;
        logic [ROUND_W-1:0]  round_idx;
        logic                chain_add;
        logic                chain_init;
        logic [WORD_W-1:0]   word_sel;
    } cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_at_len;
    } status_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== src/sha_datapath.sv =====
// Datapath: word assembly, 16-word schedule window, round logic, chaining
// words, fill count and bit count. Uses sha_pkg; driven by sha_ctrl.
module sha_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::cmd_t    cmd,
    input  logic [7:0]       data_byte,
    output sha_pkg::status_t status,
    output logic [31:0]      digest_word
);

    logic [sha_pkg::FILL_W-1:0] fill_reg;
    logic [sha_pkg::FILL_W-1:0] fill_next;
    logic [63:0]                total_reg;
    logic [63:0]                total_next;
    logic [23:0]                acc_reg;
    logic [31:0]                w_reg     [sha_pkg::SCHED_DEPTH];
    logic [31:0]                v_reg     [sha_pkg::WORDS];
    logic [31:0]                chain_reg [sha_pkg::WORDS];

    logic [7:0]  push_byte;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] choose;
    logic [31:0] major;

    always_comb
    begin
        case (cmd.byte_sel)
            sha_pkg::SEL_INPUT: push_byte = data_byte;
            sha_pkg::SEL_MARK:  push_byte = sha_pkg::PAD_MARK;
            sha_pkg::SEL_ZERO:  push_byte = 8'h00;
            sha_pkg::SEL_LEN:   push_byte = total_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:            push_byte = 8'h00;
        endcase
    end

    assign fill_next = cmd.push ? fill_reg + 1'b1 : fill_reg;

    always_comb
    begin
        total_next = total_reg;
        if (cmd.total_clear)
        begin
            total_next = '0;
        end
        else if (cmd.count_add)
        begin
            total_next = total_reg + 64'd8;
        end
    end

    assign status.fill_full   = (fill_reg == sha_pkg::FILL_LAST);
    assign status.fill_at_len = (fill_reg == sha_pkg::FILL_LEN);

    assign sched_new = w_reg[0] + sha_pkg::small_sigma0(w_reg[1]) + w_reg[9]
                     + sha_pkg::small_sigma1(w_reg[14]);

    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1     = v_reg[7] + sha_pkg::big_sigma1(v_reg[4]) + choose
                  + sha_pkg::ROUND_K[cmd.round_idx] + w_reg[0];
    assign t2     = sha_pkg::big_sigma0(v_reg[0]) + major;

    assign digest_word = chain_reg[cmd.word_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                chain_reg[i] <= sha_pkg::H_INIT[i];
            end
        end
        else
        begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
            if (cmd.chain_init)
            begin
                for (int i = 0; i < sha_pkg::WORDS; i++)
                begin
                    chain_reg[i] <= sha_pkg::H_INIT[i];
                end
            end
            else if (cmd.chain_add)
            begin
                for (int i = 0; i < sha_pkg::WORDS; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
            end
        end
    end

    // schedule window: entry 0 holds the word for the current round
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            acc_reg <= {acc_reg[15:0], push_byte};
        end
        if (cmd.push && (fill_reg[1:0] == 2'b11))
        begin
            for (int i = 0; i < sha_pkg::SCHED_DEPTH - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha_pkg::SCHED_DEPTH-1] <= {acc_reg, push_byte};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < sha_pkg::SCHED_DEPTH - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[sha_pkg::SCHED_DEPTH-1] <= sched_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < sha_pkg::WORDS; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

// ===== src/sha_ctrl.sv =====
// Controller: sequences byte intake, padding, the 64 rounds, chaining and
// digest output. Uses sha_pkg; commands sha_datapath.
module sha_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    byte_present,
    input  logic                    message_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [sha_pkg::WORD_W-1:0] word_index,
    output logic                    digest_last,
    input  sha_pkg::status_t        status,
    output sha_pkg::cmd_t           cmd
);

    sha_pkg::state_t              state_reg;
    sha_pkg::state_t              state_next;
    logic [sha_pkg::ROUND_W-1:0]  cnt_reg;
    logic [sha_pkg::ROUND_W-1:0]  cnt_next;
    logic                         fin_reg;
    logic                         fin_next;
    logic                         mark_reg;
    logic                         mark_next;
    logic                         len_reg;
    logic                         len_next;
    logic                         len_now;
    logic                         out_done;

    assign len_now  = len_reg | status.fill_at_len;
    assign out_done = out_ready && (cnt_reg[sha_pkg::WORD_W-1:0] == sha_pkg::WORD_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        mark_next  = mark_reg;
        len_next   = len_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present && status.fill_full)
                    begin
                        state_next = sha_pkg::ST_ROUND;
                        fin_next   = message_end;
                    end
                    else if (message_end)
                    begin
                        state_next = sha_pkg::ST_MARK;
                        fin_next   = 1'b1;
                    end
                end
            end
            sha_pkg::ST_MARK:
            begin
                mark_next  = 1'b1;
                state_next = status.fill_full ? sha_pkg::ST_ROUND : sha_pkg::ST_PAD;
            end
            sha_pkg::ST_PAD:
            begin
                len_next = len_now;
                if (status.fill_full)
                begin
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sha_pkg::ROUND_LAST)
                begin
                    state_next = sha_pkg::ST_CHAIN;
                end
            end
            sha_pkg::ST_CHAIN:
            begin
                if (!fin_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (len_reg)
                begin
                    state_next = sha_pkg::ST_OUT;
                end
                else if (mark_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_MARK;
                end
            end
            sha_pkg::ST_OUT:
            begin
                if (out_done)
                begin
                    state_next = sha_pkg::ST_IDLE;
                    cnt_next   = '0;
                    fin_next   = 1'b0;
                    mark_next  = 1'b0;
                    len_next   = 1'b0;
                end
                else if (out_ready)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.byte_sel    = sha_pkg::SEL_INPUT;
        cmd.round_idx   = cnt_reg;
        cmd.word_sel    = cnt_reg[sha_pkg::WORD_W-1:0];
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && byte_present)
                begin
                    cmd.push      = 1'b1;
                    cmd.count_add = 1'b1;
                    cmd.load_work = status.fill_full;
                end
            end
            sha_pkg::ST_MARK:
            begin
                cmd.push      = 1'b1;
                cmd.byte_sel  = sha_pkg::SEL_MARK;
                cmd.load_work = status.fill_full;
            end
            sha_pkg::ST_PAD:
            begin
                cmd.push      = 1'b1;
                cmd.byte_sel  = len_now ? sha_pkg::SEL_LEN : sha_pkg::SEL_ZERO;
                cmd.load_work = status.fill_full;
            end
            sha_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            sha_pkg::ST_CHAIN:
            begin
                cmd.chain_add = 1'b1;
            end
            sha_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_done)
                begin
                    cmd.chain_init  = 1'b1;
                    cmd.total_clear = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign word_index  = cnt_reg[sha_pkg::WORD_W-1:0];
    assign digest_last = (cnt_reg[sha_pkg::WORD_W-1:0] == sha_pkg::WORD_LAST);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    a_len_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg |-> (fin_reg && mark_reg))
        else $error("length phase without pad mark");

    a_rounds_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && cnt_reg != sha_pkg::ROUND_LAST)
        |=> (state_reg == sha_pkg::ST_ROUND && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("round sequence broken");

    a_out_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (cnt_reg == '0 && len_reg))
        else $error("digest output started out of sequence");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_done) |=> (state_reg == sha_pkg::ST_IDLE && !fin_reg))
        else $error("hasher did not restart after digest");

endmodule

// ===== src/sha256_stream_hasher.sv =====
// SHA-256 stream hasher, top level: one message byte per input item.
// Each full block is then compressed by the single shared round unit in the
// round and chaining states; no new byte is taken until that is done.
// Message end: pad mark, zero bytes and the bit length, one or two
// compressions, then eight digest items, one per cycle when out_ready is set.
// Reset (async, active low) loads the initial hash values and clears counts.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_present (byte_present),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_index   (word_index),
        .digest_last  (digest_last),
        .status       (status),
        .cmd          (cmd)
    );

    sha_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule
